[rtl/core/irf_pkg.sv]
package irf_pkg;

	// Configuration register indexes.
	localparam logic [1:0] REG_BASE   = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_SIGNED = 2'd2;

	// Radix codes held in the base register.
	localparam logic [1:0] BASE_BIN = 2'd0;
	localparam logic [1:0] BASE_DEC = 2'd1;
	localparam logic [1:0] BASE_HEX = 2'd2;

	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned BCD_DIGS = 10;

	// ASCII codes used by the formatter.
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_LOW_B = 8'h62;
	localparam logic [7:0] CHAR_LOW_X = 8'h78;

	// What the datapath puts on the output in a given cycle.
	localparam logic [2:0] EMIT_ZERO  = 3'd0;
	localparam logic [2:0] EMIT_B     = 3'd1;
	localparam logic [2:0] EMIT_X     = 3'd2;
	localparam logic [2:0] EMIT_MINUS = 3'd3;
	localparam logic [2:0] EMIT_BIN   = 3'd4;
	localparam logic [2:0] EMIT_HEX   = 3'd5;
	localparam logic [2:0] EMIT_DEC   = 3'd6;

	typedef struct packed {
		logic       load;
		logic       step;
		logic       emit;
		logic [2:0] kind;
		logic       last;
		logic [4:0] idx;
	} cmd_t;

	typedef struct packed {
		logic       neg;
		logic [3:0] lead_idx;
	} stat_t;

	// Width register as used: zero counts as one, anything above 32 as 32.
	function automatic logic [5:0] eff_width(input logic [5:0] w);
		logic [5:0] r;
		if (w == 6'd0) begin
			r = 6'd1;
		end else if (w > 6'd32) begin
			r = 6'd32;
		end else begin
			r = w;
		end
		return r;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] d);
		logic [7:0] r;
		if (d < 4'd10) begin
			r = CHAR_ZERO + {4'b0000, d};
		end else begin
			r = CHAR_UPPER_A + {4'b0000, d} - 8'd10;
		end
		return r;
	endfunction

endpackage

[rtl/core/irf_ctrl.sv]
module irf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       base,
	input  logic [5:0]       width,
	input  irf_pkg::stat_t   stat,
	output irf_pkg::cmd_t    cmd,
	output logic             busy
);
	import irf_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CONV = 3'd1;
	localparam logic [2:0] S_LEAD = 3'd2;
	localparam logic [2:0] S_PFX0 = 3'd3;
	localparam logic [2:0] S_PFX1 = 3'd4;
	localparam logic [2:0] S_BODY = 3'd5;

	logic [2:0] state_q, state_d;
	logic [4:0] cnt_q, cnt_d;
	logic [5:0] wm1;

	assign busy = (state_q != S_IDLE);
	assign wm1  = width - 6'd1;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		cmd.idx  = cnt_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					case (base)
						BASE_BIN, BASE_HEX: state_d = S_PFX0;
						BASE_DEC: begin
							state_d = S_CONV;
							cnt_d   = 5'd31;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_CONV: begin
				cmd.step = 1'b1;
				cnt_d    = cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					state_d = S_LEAD;
				end
			end
			S_LEAD: begin
				cmd.emit = stat.neg;
				cmd.kind = EMIT_MINUS;
				cnt_d    = {1'b0, stat.lead_idx};
				state_d  = S_BODY;
			end
			S_PFX0: begin
				cmd.emit = 1'b1;
				cmd.kind = EMIT_ZERO;
				state_d  = S_PFX1;
			end
			S_PFX1: begin
				cmd.emit = 1'b1;
				if (base == BASE_BIN) begin
					cmd.kind = EMIT_B;
					cnt_d    = wm1[4:0];
				end else begin
					cmd.kind = EMIT_X;
					cnt_d    = {2'b00, wm1[4:2]};
				end
				state_d = S_BODY;
			end
			S_BODY: begin
				cmd.emit = 1'b1;
				case (base)
					BASE_BIN: cmd.kind = EMIT_BIN;
					BASE_HEX: cmd.kind = EMIT_HEX;
					default:  cmd.kind = EMIT_DEC;
				endcase
				cmd.last = (cnt_q == 5'd0);
				cnt_d    = cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	a_conv_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CONV && cnt_q == 5'd0) |=> state_q == S_LEAD)
		else $error("conversion loop did not hand over to the lead state");

	a_last_idles: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.last) |=> state_q == S_IDLE)
		else $error("controller still busy after the final character");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (state_q == S_IDLE && !cmd.emit))
		else $error("load issued outside idle");

endmodule

[rtl/core/irf_dp.sv]
module irf_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [31:0]      value,
	input  logic [1:0]       base,
	input  logic [5:0]       width,
	input  logic             signed_mode,
	input  irf_pkg::cmd_t    cmd,
	output irf_pkg::stat_t   stat,
	output logic [7:0]       char_code,
	output logic             last_char,
	output logic             char_valid
);
	import irf_pkg::*;

	localparam int unsigned BCD_W = 4 * BCD_DIGS;

	logic [VALUE_W-1:0] val_q;
	logic [VALUE_W-1:0] sh_q;
	logic [BCD_W-1:0]   bcd_q;
	logic               neg_q;
	logic [7:0]         char_q;
	logic               last_q;
	logic               valid_q;

	logic [VALUE_W-1:0] mask;
	logic [VALUE_W-1:0] masked;
	logic [5:0]         shamt;
	logic [5:0]         wm1;
	logic               top_bit;
	logic               neg_d;
	logic [BCD_W-1:0]   bcd_adj;
	logic [3:0]         hex_dig;
	logic [3:0]         dec_dig;
	logic [7:0]         char_d;

	function automatic logic bcd_ok(input logic [BCD_W-1:0] b);
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < BCD_DIGS; i++) begin
			if (b[4*i +: 4] > 4'd9) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

	assign shamt   = 6'd32 - width;
	assign mask    = {VALUE_W{1'b1}} >> shamt;
	assign masked  = value & mask;
	assign wm1     = width - 6'd1;
	assign top_bit = masked[wm1[4:0]];
	assign neg_d   = signed_mode && (base == BASE_DEC) && top_bit;

	// Add-three correction on every BCD digit ahead of the shift.
	always_comb begin
		for (int i = 0; i < BCD_DIGS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// Highest nonzero decimal digit; zero itself prints as one digit.
	always_comb begin
		stat.neg      = neg_q;
		stat.lead_idx = '0;
		for (int i = 0; i < BCD_DIGS; i++) begin
			if (bcd_q[4*i +: 4] != 4'd0) begin
				stat.lead_idx = 4'(i);
			end
		end
	end

	assign hex_dig = val_q[{cmd.idx[2:0], 2'b00} +: 4];
	assign dec_dig = bcd_q[{cmd.idx[3:0], 2'b00} +: 4];

	always_comb begin
		case (cmd.kind)
			EMIT_ZERO:  char_d = CHAR_ZERO;
			EMIT_B:     char_d = CHAR_LOW_B;
			EMIT_X:     char_d = CHAR_LOW_X;
			EMIT_MINUS: char_d = CHAR_MINUS;
			EMIT_BIN:   char_d = CHAR_ZERO + {7'd0, val_q[cmd.idx]};
			EMIT_HEX:   char_d = hex_char(hex_dig);
			EMIT_DEC:   char_d = CHAR_ZERO + {4'd0, dec_dig};
			default:    char_d = CHAR_ZERO;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q <= masked;
			neg_q <= neg_d;
			sh_q  <= neg_d ? ((~masked + 32'd1) & mask) : masked;
			bcd_q <= '0;
		end else if (cmd.step) begin
			sh_q  <= {sh_q[VALUE_W-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], sh_q[VALUE_W-1]};
		end
		char_q <= char_d;
		last_q <= cmd.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.emit;
		end
	end

	assign char_code  = char_q;
	assign last_char  = last_q;
	assign char_valid = valid_q;

	a_strobe_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> valid_q)
		else $error("emit command did not raise the strobe");

	a_shift: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> sh_q == {$past(sh_q[VALUE_W-2:0]), 1'b0})
		else $error("magnitude register did not shift on a conversion step");

	a_bcd_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> bcd_ok(bcd_q))
		else $error("BCD digit out of range after a conversion step");

endmodule

[rtl/core/integer_radix_formatter_top.sv]
// Integer radix formatter. A 32-bit value is transferred in at a rising clock edge with start
// high and busy low, and its ASCII text comes out one character per cycle, most significant
// first, on char_code with char_valid high for exactly one cycle; last_char marks the final
// character. There is no back-pressure on the result side: the receiver must take every
// character in the cycle it appears. One item is worked on at a time. Binary output of a
// w-bit value gives two prefix characters and then w bits, after which the controller returns
// to idle for the next transfer. Hexadecimal gives the prefix and ceil(w/4) digits. Decimal
// first runs the binary-to-BCD shift loop, which always runs 32 steps, then a lead step that
// emits a minus sign if the value is negative, then the digits. With base code 3 a start is
// taken and nothing is emitted. The configuration registers may only be written while busy is
// low and the previous text has been fully delivered.
module integer_radix_formatter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] value,
	output logic [7:0]  char_code,
	output logic        last_char,
	output logic        char_valid,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [5:0]  wr_data
);
	import irf_pkg::*;

	logic [1:0] base_q;
	logic [5:0] width_q;
	logic       signed_q;
	logic [5:0] width_eff;
	logic       start_ok;
	cmd_t       cmd;
	stat_t      stat;

	// Configuration registers. An index beyond the list is simply ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= BASE_DEC;
			width_q  <= 6'd32;
			signed_q <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				REG_BASE:   base_q   <= wr_data[1:0];
				REG_WIDTH:  width_q  <= wr_data;
				REG_SIGNED: signed_q <= wr_data[0];
				default: begin
				end
			endcase
		end
	end

	// The stored width is clamped into 1..32 before anything uses it.
	assign width_eff = eff_width(width_q);

	// The controller sees start only when a transfer actually happens.
	assign start_ok = start && !busy;

	irf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_ok),
		.base   (base_q),
		.width  (width_eff),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	irf_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.value       (value),
		.base        (base_q),
		.width       (width_eff),
		.signed_mode (signed_q),
		.cmd         (cmd),
		.stat        (stat),
		.char_code   (char_code),
		.last_char   (last_char),
		.char_valid  (char_valid)
	);

endmodule
